// ----- design/asa_pkg.sv -----
// Shared types and constants for the aligned stack allocator.
// Used by asa_record_mem and aligned_stack_allocator; no dependencies.
package asa_pkg;

	localparam int unsigned POOL_BYTES_DEF     = 4096;
	localparam int unsigned MAX_ALIGN_LOG2_DEF = 4;

	localparam int unsigned POOL_SIZE_W = 13;
	localparam int unsigned SIZE_W      = 12;
	localparam int unsigned LG_W        = 3;
	localparam int unsigned PAD_W       = 4;

	localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 13'd4096;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} asa_cmd_t;

	typedef struct packed {
		asa_cmd_t          command;
		logic [SIZE_W-1:0] request_size;
		logic [LG_W-1:0]   align_log2;
	} asa_item_t;

	typedef struct packed {
		logic                   granted;
		logic [SIZE_W-1:0]      block_address;
		logic [POOL_SIZE_W-1:0] space_left;
	} asa_result_t;

	// One alignment record: previous header flag and the padding amount.
	typedef struct packed {
		logic             prev_hdr;
		logic [PAD_W-1:0] pad;
	} asa_rec_t;

endpackage

// ----- design/aligned_stack_allocator.sv -----
// Aligned stack allocator top level: command decode, top/flag state, result.
// Depends on asa_pkg and asa_record_mem.
//
// Usage:
//   An item (command, request_size, align_log2) is taken at a rising edge with
//   start high and busy low. Each item gives one result, shown on result for
//   exactly one cycle with done high; the receiver cannot stall it.
//   Allocate: result in the cycle after acceptance; the record write to the
//   store happens at the accepting edge, so a new item may follow at once.
//   Free: the record must first come out of the synchronous record store, so
//   busy is high for one cycle, in ST_FREE; done rises as the block leaves it.
//   Throughput is one allocate per cycle; a free takes no new item while busy.
//   pool_size is written with cfg_we/cfg_wdata, by the user only while the block
//   is idle (the block does not enforce it); values above POOL_BYTES act as POOL_BYTES.
//   Reset (arst_n low) clears top and the header flag, sets pool_size to 4096
//   and drops done/busy. The record store is not cleared: no clearing pass,
//   since records are always written before a well-ordered free reads them.
module aligned_stack_allocator #(
	parameter int unsigned POOL_BYTES     = asa_pkg::POOL_BYTES_DEF,
	parameter int unsigned MAX_ALIGN_LOG2 = asa_pkg::MAX_ALIGN_LOG2_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  asa_pkg::asa_item_t                   item,
	output logic                                 done,
	output asa_pkg::asa_result_t                 result,
	input  logic                                 cfg_we,
	input  logic [asa_pkg::POOL_SIZE_W-1:0]      cfg_wdata
);
	import asa_pkg::*;

	localparam int unsigned TW = $clog2(POOL_BYTES + 1);
	localparam int unsigned AW = $clog2(POOL_BYTES);
	localparam int unsigned CW = ((TW > POOL_SIZE_W) ? TW : POOL_SIZE_W) + 1;
	localparam int unsigned SW = ((TW > SIZE_W) ? TW : SIZE_W) + 2;

	typedef enum logic {
		ST_IDLE,
		ST_FREE
	} state_t;

	state_t                 state_q;
	logic [TW-1:0]          top_q;
	logic                   hdr_q;
	logic [POOL_SIZE_W-1:0] pool_size_q;
	logic                   done_q;
	asa_result_t            result_q;

	// Free in flight
	logic [SW-1:0]          rec_pos_q;
	logic                   rec_ok_q;
	logic                   free_hdr_q;
	logic [SIZE_W-1:0]      free_size_q;

	function automatic logic [TW-1:0] space_of(logic [TW-1:0] t, logic [TW-1:0] p);
		return (t >= p) ? '0 : TW'(p - t);
	endfunction

	logic            accept;
	logic [TW-1:0]   pool_cur;
	logic [TW-1:0]   space_cur;

	assign accept   = start && !busy;
	assign pool_cur = (CW'(pool_size_q) > CW'(POOL_BYTES)) ? TW'(POOL_BYTES)
	                                                       : TW'(pool_size_q);
	assign space_cur = space_of(top_q, pool_cur);

	// Allocate path
	logic [LG_W-1:0]  lg_sat;
	logic [PAD_W:0]   align;
	logic [PAD_W-1:0] mask;
	logic [PAD_W-1:0] pad;
	logic [TW-1:0]    alloc_base;
	logic [TW-1:0]    end_pos;
	logic [TW-1:0]    wpos;
	logic [TW-1:0]    top_alloc;
	logic             fit;
	logic             hdr_new;

	always_comb begin
		lg_sat     = (item.align_log2 > LG_W'(MAX_ALIGN_LOG2)) ? LG_W'(MAX_ALIGN_LOG2)
		                                                       : item.align_log2;
		align      = (PAD_W+1)'(1) << lg_sat;
		mask       = PAD_W'(align - (PAD_W+1)'(1));
		pad        = (~top_q[PAD_W-1:0] + PAD_W'(1)) & mask;
		alloc_base = top_q + TW'(pad);
		end_pos    = alloc_base + TW'(item.request_size);
		fit        = CW'(space_cur) >= (CW'(item.request_size) + CW'(align));
		hdr_new    = (pad != '0);
		// header sits just below the block, footer just above it
		wpos       = hdr_new ? (alloc_base - TW'(1)) : end_pos;
		top_alloc  = hdr_new ? end_pos : (end_pos + TW'(1));
	end

	// Free path, first cycle: where the record lives
	logic [SW-1:0] rec_pos;

	always_comb begin
		if (hdr_q) begin
			rec_pos = SW'(top_q) - SW'(item.request_size) - SW'(1);
		end else begin
			rec_pos = SW'(top_q) - SW'(1);
		end
	end

	// Free path, second cycle: restore top from the record
	asa_rec_t      rdata;
	asa_rec_t      rec;
	logic [SW-1:0] newtop_x;
	logic [TW-1:0] newtop;

	always_comb begin
		rec = rec_ok_q ? rdata : '0;
		if (free_hdr_q) begin
			newtop_x = rec_pos_q - SW'(rec.pad) + SW'(1);
		end else begin
			newtop_x = rec_pos_q - SW'(free_size_q) - SW'(rec.pad);
		end
		newtop = newtop_x[SW-1] ? '0 : newtop_x[TW-1:0];
	end

	logic     mem_we;
	logic     mem_re;
	asa_rec_t mem_wdata;

	assign mem_we    = accept && (item.command == CMD_ALLOC) && fit;
	assign mem_re    = accept && (item.command == CMD_FREE);
	assign mem_wdata = '{prev_hdr: hdr_q, pad: pad};

	asa_record_mem #(
		.DEPTH (POOL_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wpos[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rec_pos[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_SIZE_RESET;
		end else if (cfg_we) begin
			pool_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			hdr_q       <= 1'b0;
			done_q      <= 1'b0;
			result_q    <= '0;
			rec_pos_q   <= '0;
			rec_ok_q    <= 1'b0;
			free_hdr_q  <= 1'b0;
			free_size_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.command == CMD_ALLOC) begin
							done_q <= 1'b1;
							result_q.granted <= fit;
							if (fit) begin
								top_q                  <= top_alloc;
								hdr_q                  <= hdr_new;
								result_q.block_address <= SIZE_W'(alloc_base);
								result_q.space_left    <=
									POOL_SIZE_W'(space_of(top_alloc, pool_cur));
							end else begin
								result_q.block_address <= '0;
								result_q.space_left    <= POOL_SIZE_W'(space_cur);
							end
						end else begin
							state_q     <= ST_FREE;
							rec_pos_q   <= rec_pos;
							rec_ok_q    <= !rec_pos[SW-1];
							free_hdr_q  <= hdr_q;
							free_size_q <= item.request_size;
						end
					end
				end
				ST_FREE: begin
					state_q                <= ST_IDLE;
					done_q                 <= 1'b1;
					top_q                  <= newtop;
					hdr_q                  <= rec.prev_hdr;
					result_q.granted       <= 1'b1;
					result_q.block_address <= '0;
					result_q.space_left    <= POOL_SIZE_W'(space_of(newtop, pool_cur));
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q == ST_FREE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// a free holds the block off for exactly one cycle
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// every result comes from an accepted allocate or a finishing free
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without an item");

	// the top never passes the end of the store
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(top_q) <= CW'(POOL_BYTES))
		else $error("top beyond pool");

	// a refused allocate leaves top and flag untouched
	a_refuse_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.command == CMD_ALLOC) && !fit) |=>
			($stable(top_q) && $stable(hdr_q)))
		else $error("refused allocate changed state");
`endif

endmodule

// ----- design/asa_record_mem.sv -----
// Record store: one alignment record per pool byte, synchronous read.
// Depends on asa_pkg for the record type.
module asa_record_mem #(
	parameter int unsigned DEPTH = asa_pkg::POOL_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  asa_pkg::asa_rec_t          wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output asa_pkg::asa_rec_t          rdata
);
	import asa_pkg::*;

	asa_rec_t mem [DEPTH];
	asa_rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
